// File: sv/hre_pkg.sv
`timescale 1ns / 1ps

package hre_pkg;

    // Command codes carried in the input tuser field.
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Characters that are not hex digits.
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // One classified job handed from the front end to the character sequencer.
    // Bytes are printed from byte 0 upward, two hex digits each.
    typedef struct packed {
        logic        colon;     // lead the run with ':'
        logic        four;      // four bytes to print, otherwise one
        logic        crlf;      // close the run with CR LF
        logic [31:0] bytes;     // byte 0 in bits [7:0]
    } t_job;

endpackage

// File: sv/hre_front.sv
`timescale 1ns / 1ps

module hre_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_cmd,
    input  logic [7:0]       i_byte_count,
    input  logic [15:0]      i_record_address,
    input  logic [7:0]       i_record_type,
    input  logic             i_no_newline,
    input  logic [7:0]       i_data_byte,
    input  logic             i_q_full,
    output logic             o_push,
    output hre_pkg::t_job    o_job
);

    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic       r_suppress;
    logic       n_suppress;
    logic       w_accept;
    logic       w_emit;
    hre_pkg::t_cmd w_cmd;

    assign w_cmd    = hre_pkg::t_cmd'(i_cmd);
    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign o_push   = w_accept && w_emit;

    // Classify the command, build its job and work out the next running sum.
    always_comb begin
        n_sum      = r_sum;
        n_suppress = r_suppress;
        w_emit     = 1'b1;
        o_job      = '0;
        unique case (w_cmd)
            hre_pkg::CMD_START: begin
                n_sum      = i_byte_count + i_record_address[15:8]
                           + i_record_address[7:0] + i_record_type;
                n_suppress = i_no_newline;
                o_job.colon = 1'b1;
                o_job.four  = 1'b1;
                o_job.bytes = {i_record_type, i_record_address[7:0],
                               i_record_address[15:8], i_byte_count};
            end
            hre_pkg::CMD_DATA: begin
                n_sum       = r_sum + i_data_byte;
                o_job.bytes = {24'd0, i_data_byte};
            end
            hre_pkg::CMD_END: begin
                // Two's complement of the sum; a zero sum gives 00.
                o_job.bytes = {24'd0, 8'd0 - r_sum};
                o_job.crlf  = !r_suppress;
            end
            hre_pkg::CMD_NONE: begin
                w_emit = 1'b0;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // Running checksum state advances only on an accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_suppress <= 1'b0;
        end else if (w_accept) begin
            r_sum      <= n_sum;
            r_suppress <= n_suppress;
        end
    end

endmodule

// File: sv/hre_fifo.sv
`timescale 1ns / 1ps

module hre_fifo #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hre_pkg::t_job    i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output hre_pkg::t_job    o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    hre_pkg::t_job r_slot [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Entry storage; no reset needed on payload.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: sv/hre_back.sv
`timescale 1ns / 1ps

module hre_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hre_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [7:0]       o_char,
    output logic             o_last
);

    logic [3:0] r_idx;
    logic [3:0] w_len;
    logic [3:0] w_hexlen;
    logic [3:0] w_pos;
    logic [7:0] w_byte;
    logic [3:0] w_nib;
    logic [7:0] w_char;
    logic       w_last;
    logic       w_adv;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'd0, nib};
        end else begin
            ch = 8'h37 + {4'd0, nib};
        end
        return ch;
    endfunction

    // Run length and position of the current character inside the run.
    assign w_hexlen = i_job.four ? 4'd8 : 4'd2;
    assign w_len    = {3'd0, i_job.colon} + w_hexlen + (i_job.crlf ? 4'd2 : 4'd0);
    assign w_pos    = r_idx - {3'd0, i_job.colon};
    assign w_last   = (r_idx == w_len - 4'd1);

    // Pick the byte and nibble that the position points at.
    always_comb begin
        case (w_pos[2:1])
            2'd0:    w_byte = i_job.bytes[7:0];
            2'd1:    w_byte = i_job.bytes[15:8];
            2'd2:    w_byte = i_job.bytes[23:16];
            default: w_byte = i_job.bytes[31:24];
        endcase
        w_nib = w_pos[0] ? w_byte[3:0] : w_byte[7:4];
    end

    // Character select: colon, hex digit, then CR and LF.
    always_comb begin
        if (i_job.colon && (r_idx == 4'd0)) begin
            w_char = hre_pkg::CHAR_COLON;
        end else if (w_pos < w_hexlen) begin
            w_char = hex_char(w_nib);
        end else if (w_pos == w_hexlen) begin
            w_char = hre_pkg::CHAR_CR;
        end else begin
            w_char = hre_pkg::CHAR_LF;
        end
    end

    // One character per cycle whenever the output register is free or draining.
    assign w_adv    = i_valid && (!r_out_valid || i_tready);
    assign o_pop    = w_adv && w_last;
    assign o_tvalid = r_out_valid;
    assign o_char   = r_out_char;
    assign o_last   = r_out_last;

    // Character counter within the current job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_adv) begin
            r_idx <= w_last ? 4'd0 : r_idx + 4'd1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
        end
    end

`ifndef SYNTH
    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (r_idx < w_len))
        else $error("character index past end of run");

    a_idx_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |-> (r_idx == 4'd0))
        else $error("character index nonzero with no job pending");

    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_last) |=> (r_idx == 4'd0))
        else $error("run did not restart after its last character");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_last) |=> (r_idx == $past(r_idx) + 4'd1))
        else $error("character index did not step by one");
`endif

endmodule

// File: sv/hex_record_encoder_core.sv
`timescale 1ns / 1ps
// Hex object-file record encoder, one ASCII character per output transfer.
// Input channel (s): tuser carries the command (start, data, end; code 3
// is accepted and dropped). tdata carries the record fields, see below.
// Output channel (m): tdata is the character, tlast marks the last
// character caused by one input command.
// A start command prints ':' and eight hex digits (9 characters) and seeds
// the byte sum; a data command prints two digits; an end command prints the
// checksum as two digits, then CR LF unless the start asked to omit them.
// With nothing queued ahead, a command's job is first written into the job
// queue and its first character is then registered in the output register.
// Throughput: one character per cycle while the output is not stalled, set
// by the single output register of the character sequencer. The front end
// and a small job queue keep accepting commands while the output is stalled,
// until the queue fills.
// Reset clears the byte sum, the newline flag, the queue and the output.

module hex_record_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] byte_count, [23:8] record_address, [31:24] record_type,
    // [32] no_newline, [40:33] data_byte, [47:41] zero
    input  logic [47:0] i_s_tdata,
    // [1:0] cmd
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] ascii_char
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);

    logic          w_q_full;
    logic          w_push;
    logic          w_pop;
    logic          w_head_valid;
    hre_pkg::t_job w_in_job;
    hre_pkg::t_job w_head_job;

    hre_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_cmd            (i_s_tuser),
        .i_byte_count     (i_s_tdata[7:0]),
        .i_record_address (i_s_tdata[23:8]),
        .i_record_type    (i_s_tdata[31:24]),
        .i_no_newline     (i_s_tdata[32]),
        .i_data_byte      (i_s_tdata[40:33]),
        .i_q_full         (w_q_full),
        .o_push           (w_push),
        .o_job            (w_in_job)
    );

    hre_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_job   (w_head_job)
    );

    hre_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_head_valid),
        .i_job    (w_head_job),
        .o_pop    (w_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_char   (o_m_tdata),
        .o_last   (o_m_tlast)
    );

endmodule
